@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file cheb2d_checker.sv
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHEB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CHEB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cheb2d_pkg.sv @@
// shared constants and types of the bivariate chebyshev series evaluator
// no dependencies
`default_nettype none

package cheb2d_pkg;

    localparam int MAX_ORDER_X = 7;
    localparam int MAX_ORDER_Y = 7;
    localparam int COEFF_WIDTH = 32;

    localparam int PT_WIDTH        = 18;
    localparam int IN_COEFF_WIDTH  = 32;
    localparam int IDX_WIDTH       = 3;
    localparam int DEG_WIDTH       = 3;
    localparam int OUT_WIDTH       = 48;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEGREE_X = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEGREE_Y = 1'b1;

    localparam logic [DEG_WIDTH-1:0] DEG_X_RESET = 3'd3;
    localparam logic [DEG_WIDTH-1:0] DEG_Y_RESET = 3'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic signed [PT_WIDTH-1:0] ONE_Q16     = 18'sd65536;
    localparam logic signed [PT_WIDTH-1:0] NEG_ONE_Q16 = -18'sd65536;

    typedef struct packed {
        logic is_eval;
        logic ld_ok;
    } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/cheb2d_if.sv @@
// request and result channel interfaces of the chebyshev series evaluator
// depends on cheb2d_pkg
`default_nettype none

interface cheb2d_item_if;
    logic                                            valid;
    logic                                            ready;
    logic                                            mode;
    logic        [cheb2d_pkg::IDX_WIDTH-1:0]         order_x_index;
    logic        [cheb2d_pkg::IDX_WIDTH-1:0]         order_y_index;
    logic signed [cheb2d_pkg::IN_COEFF_WIDTH-1:0]    coeff_value;
    logic signed [cheb2d_pkg::PT_WIDTH-1:0]          x_point;
    logic signed [cheb2d_pkg::PT_WIDTH-1:0]          y_point;

    modport source (output valid, mode, order_x_index, order_y_index, coeff_value,
                    x_point, y_point, input ready);
    modport sink   (input valid, mode, order_x_index, order_y_index, coeff_value,
                    x_point, y_point, output ready);
endinterface

interface cheb2d_result_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [cheb2d_pkg::OUT_WIDTH-1:0] series_value;
    logic                                    overflow;

    modport source (output valid, series_value, overflow, input ready);
    modport sink   (input valid, series_value, overflow, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cheb2d_front.sv @@
// front end: classifies requests, clamps operands, buffers them in a short queue
// depends on cheb2d_pkg
`default_nettype none

module cheb2d_front #(
    parameter int MAX_ORDER_X = cheb2d_pkg::MAX_ORDER_X,
    parameter int MAX_ORDER_Y = cheb2d_pkg::MAX_ORDER_Y,
    parameter int COEFF_WIDTH = cheb2d_pkg::COEFF_WIDTH
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic                                          mode,
    input  logic        [cheb2d_pkg::IDX_WIDTH-1:0]       order_x_index,
    input  logic        [cheb2d_pkg::IDX_WIDTH-1:0]       order_y_index,
    input  logic signed [cheb2d_pkg::IN_COEFF_WIDTH-1:0]  coeff_value,
    input  logic signed [cheb2d_pkg::PT_WIDTH-1:0]        x_point,
    input  logic signed [cheb2d_pkg::PT_WIDTH-1:0]        y_point,
    output logic                                          q_valid,
    input  logic                                          q_ready,
    output cheb2d_pkg::cmd_t                              q_cmd,
    output logic [$clog2((MAX_ORDER_X+1)*(MAX_ORDER_Y+1))-1:0] q_addr,
    output logic signed [COEFF_WIDTH-1:0]                 q_coeff,
    output logic signed [cheb2d_pkg::PT_WIDTH-1:0]        q_x,
    output logic signed [cheb2d_pkg::PT_WIDTH-1:0]        q_y
);

    localparam int ADW = $clog2((MAX_ORDER_X+1)*(MAX_ORDER_Y+1));
    localparam int QD  = cheb2d_pkg::QUEUE_DEPTH;
    localparam int PTW = $clog2(QD);
    localparam int CNW = $clog2(QD+1);
    localparam int TW  = cheb2d_pkg::PT_WIDTH;

    cheb2d_pkg::cmd_t              cmd_in;
    logic [ADW-1:0]                addr_in;
    logic signed [63:0]            c64;
    logic signed [63:0]            c_lo;
    logic signed [63:0]            c_hi;
    logic signed [COEFF_WIDTH-1:0] coeff_in;
    logic signed [TW-1:0]          x_in;
    logic signed [TW-1:0]          y_in;
    int                            addr_i;

    cheb2d_pkg::cmd_t              cmd_mem   [QD];
    logic [ADW-1:0]                addr_mem  [QD];
    logic signed [COEFF_WIDTH-1:0] coeff_mem [QD];
    logic signed [TW-1:0]          x_mem     [QD];
    logic signed [TW-1:0]          y_mem     [QD];

    logic [PTW-1:0] wr_ptr_reg;
    logic [PTW-1:0] rd_ptr_reg;
    logic [CNW-1:0] count_reg;
    logic           push;
    logic           pop;

    always_comb
    begin
        cmd_in.is_eval = (mode == cheb2d_pkg::MODE_EVAL);
        cmd_in.ld_ok   = (int'(order_x_index) <= MAX_ORDER_X) &&
                         (int'(order_y_index) <= MAX_ORDER_Y);
        addr_i  = int'(order_x_index) * (MAX_ORDER_Y + 1) + int'(order_y_index);
        addr_in = cmd_in.ld_ok ? ADW'(addr_i) : '0;

        // saturate the loaded value to the stored coefficient width
        c64  = 64'(coeff_value);
        c_lo = -(64'sd1 <<< (COEFF_WIDTH - 1));
        c_hi = (64'sd1 <<< (COEFF_WIDTH - 1)) - 64'sd1;
        if (c64 < c_lo)
        begin
            coeff_in = COEFF_WIDTH'(c_lo);
        end
        else if (c64 > c_hi)
        begin
            coeff_in = COEFF_WIDTH'(c_hi);
        end
        else
        begin
            coeff_in = COEFF_WIDTH'(c64);
        end

        if (x_point > cheb2d_pkg::ONE_Q16)
        begin
            x_in = cheb2d_pkg::ONE_Q16;
        end
        else if (x_point < cheb2d_pkg::NEG_ONE_Q16)
        begin
            x_in = cheb2d_pkg::NEG_ONE_Q16;
        end
        else
        begin
            x_in = x_point;
        end

        if (y_point > cheb2d_pkg::ONE_Q16)
        begin
            y_in = cheb2d_pkg::ONE_Q16;
        end
        else if (y_point < cheb2d_pkg::NEG_ONE_Q16)
        begin
            y_in = cheb2d_pkg::NEG_ONE_Q16;
        end
        else
        begin
            y_in = y_point;
        end
    end

    assign in_ready = (count_reg != CNW'(QD));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    assign q_cmd   = cmd_mem[rd_ptr_reg];
    assign q_addr  = addr_mem[rd_ptr_reg];
    assign q_coeff = coeff_mem[rd_ptr_reg];
    assign q_x     = x_mem[rd_ptr_reg];
    assign q_y     = y_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]   <= cmd_in;
            addr_mem[wr_ptr_reg]  <= addr_in;
            coeff_mem[wr_ptr_reg] <= coeff_in;
            x_mem[wr_ptr_reg]     <= x_in;
            y_mem[wr_ptr_reg]     <= y_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cheb2d_back.sv @@
// back end: coefficient memory, chebyshev recurrence and multiply-accumulate pipeline
// depends on cheb2d_pkg
`default_nettype none

module cheb2d_back #(
    parameter int MAX_ORDER_X = cheb2d_pkg::MAX_ORDER_X,
    parameter int MAX_ORDER_Y = cheb2d_pkg::MAX_ORDER_Y,
    parameter int COEFF_WIDTH = cheb2d_pkg::COEFF_WIDTH
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          q_valid,
    output logic                                          q_ready,
    input  cheb2d_pkg::cmd_t                              q_cmd,
    input  logic [$clog2((MAX_ORDER_X+1)*(MAX_ORDER_Y+1))-1:0] q_addr,
    input  logic signed [COEFF_WIDTH-1:0]                 q_coeff,
    input  logic signed [cheb2d_pkg::PT_WIDTH-1:0]        q_x,
    input  logic signed [cheb2d_pkg::PT_WIDTH-1:0]        q_y,
    input  logic        [cheb2d_pkg::DEG_WIDTH-1:0]       degree_x,
    input  logic        [cheb2d_pkg::DEG_WIDTH-1:0]       degree_y,
    output logic                                          rsp_valid,
    input  logic                                          rsp_ready,
    output logic signed [cheb2d_pkg::OUT_WIDTH-1:0]       rsp_value,
    output logic                                          rsp_ovf
);

    localparam int DEPTH = (MAX_ORDER_X + 1) * (MAX_ORDER_Y + 1);
    localparam int ADW   = $clog2(DEPTH);
    localparam int MW    = $clog2(MAX_ORDER_X + 1);
    localparam int NW    = $clog2(MAX_ORDER_Y + 1);
    localparam int MAXO  = (MAX_ORDER_X > MAX_ORDER_Y) ? MAX_ORDER_X : MAX_ORDER_Y;
    localparam int KW    = $clog2(MAXO + 2);
    localparam int ROW   = MAX_ORDER_Y + 1;
    localparam int TW    = cheb2d_pkg::PT_WIDTH;
    localparam int OW    = cheb2d_pkg::OUT_WIDTH;
    localparam int PW    = COEFF_WIDTH + TW;
    localparam int SW    = PW + NW;
    localparam int AMW   = SW - 15;
    localparam int P2W   = AMW + TW;
    localparam int ACW   = P2W + MW;
    localparam int ZW    = ACW - 15;
    localparam int EW    = (ZW > OW + 1) ? ZW : OW + 1;
    localparam int RW    = 2 * TW + 2;

    localparam logic signed [EW-1:0] ZMAX = (EW'(1) <<< (OW - 1)) - EW'(1);
    localparam logic signed [EW-1:0] ZMIN = -(EW'(1) <<< (OW - 1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_TGEN,
        S_ISSUE,
        S_DRAIN,
        S_FIN
    } state_t;

    state_t state_reg;

    logic signed [COEFF_WIDTH-1:0] mem [DEPTH];
    logic signed [COEFF_WIDTH-1:0] rdata_reg;
    logic                          mem_we;

    logic signed [TW-1:0] x_reg;
    logic signed [TW-1:0] y_reg;
    logic [MW-1:0]        dx_reg;
    logic [NW-1:0]        dy_reg;
    logic                 axis_reg;
    logic [KW-1:0]        k_reg;
    logic signed [TW-1:0] t1_reg;
    logic signed [TW-1:0] t2_reg;
    logic signed [TW-1:0] tx_reg [MAX_ORDER_X+1];
    logic signed [TW-1:0] ty_reg [MAX_ORDER_Y+1];

    logic [MW-1:0]  m_reg;
    logic [NW-1:0]  n_reg;
    logic [ADW-1:0] addr_reg;
    logic [ADW-1:0] base_reg;

    logic          s1_v_reg, s1_first_reg, s1_lastn_reg, s1_last_reg;
    logic [NW-1:0] s1_n_reg;
    logic [MW-1:0] s1_m_reg;
    logic          s2_v_reg, s2_first_reg, s2_lastn_reg, s2_last_reg;
    logic [MW-1:0] s2_m_reg;
    logic          s3_v_reg, s3_last_reg;
    logic [MW-1:0] s3_m_reg;
    logic          s4_v_reg, s4_last_reg;

    logic signed [PW-1:0]  p1_reg;
    logic signed [SW-1:0]  am_reg;
    logic signed [AMW-1:0] amr_reg;
    logic signed [P2W-1:0] p2_reg;
    logic signed [ACW-1:0] acc_reg;

    logic                  out_valid_reg;
    logic signed [OW-1:0]  out_value_reg;
    logic                  out_ovf_reg;

    // recurrence datapath
    logic signed [TW-1:0]     t_sel;
    logic signed [2*TW-1:0]   tprod;
    logic signed [RW-1:0]     tdbl;
    logic signed [RW-17:0]    tr;
    logic signed [RW-16:0]    tsub;
    logic signed [TW-1:0]     tnew;
    logic                     tgen_done;
    logic [KW-1:0]            deg_sel;

    // accumulate datapath
    logic signed [SW-1:0]  am_base;
    logic signed [SW-1:0]  am_sum;
    logic signed [SW:0]    am_rsum;
    logic signed [ACW:0]   acc_rsum;
    logic signed [EW-1:0]  z_ext;
    logic signed [OW-1:0]  z_sat;
    logic                  z_ovf;

    logic          take;
    logic          start_eval;
    logic          issue_lastn;
    logic          issue_last;
    logic          out_free;
    logic [MW-1:0] dx_next;
    logic [NW-1:0] dy_next;

    assign q_ready    = (state_reg == S_IDLE);
    assign take       = q_valid && q_ready;
    assign start_eval = take && q_cmd.is_eval;
    assign mem_we     = take && !q_cmd.is_eval && q_cmd.ld_ok;
    assign out_free   = !out_valid_reg || rsp_ready;

    assign issue_lastn = (n_reg == dy_reg);
    assign issue_last  = issue_lastn && (m_reg == dx_reg);

    always_comb
    begin
        if (int'(degree_x) > MAX_ORDER_X)
        begin
            dx_next = MW'(MAX_ORDER_X);
        end
        else
        begin
            dx_next = MW'(degree_x);
        end
        if (int'(degree_y) > MAX_ORDER_Y)
        begin
            dy_next = NW'(MAX_ORDER_Y);
        end
        else
        begin
            dy_next = NW'(degree_y);
        end
    end

    // T_k = rnd16(2 t T_(k-1)) - T_(k-2), clamped to [-1, 1]
    always_comb
    begin
        t_sel   = axis_reg ? x_reg : y_reg;
        deg_sel = axis_reg ? KW'(dx_reg) : KW'(dy_reg);
        tgen_done = (k_reg > deg_sel);
        tprod   = t_sel * t1_reg;
        tdbl    = $signed({tprod[2*TW-1], tprod, 1'b0}) + RW'(32768);
        tr      = tdbl[RW-1:16];
        tsub    = (RW-15)'(tr) - (RW-15)'(t2_reg);
        if (tsub > (RW-15)'(cheb2d_pkg::ONE_Q16))
        begin
            tnew = cheb2d_pkg::ONE_Q16;
        end
        else if (tsub < (RW-15)'(cheb2d_pkg::NEG_ONE_Q16))
        begin
            tnew = cheb2d_pkg::NEG_ONE_Q16;
        end
        else
        begin
            tnew = TW'(tsub);
        end
    end

    always_comb
    begin
        am_base  = s2_first_reg ? '0 : am_reg;
        am_sum   = am_base + SW'(p1_reg);
        am_rsum  = (SW+1)'(am_sum) + (SW+1)'(32768);
        acc_rsum = (ACW+1)'(acc_reg) + (ACW+1)'(32768);
        z_ext    = EW'($signed(acc_rsum[ACW:16]));
        if (z_ext > ZMAX)
        begin
            z_sat = OW'(ZMAX);
            z_ovf = 1'b1;
        end
        else if (z_ext < ZMIN)
        begin
            z_sat = OW'(ZMIN);
            z_ovf = 1'b1;
        end
        else
        begin
            z_sat = OW'(z_ext);
            z_ovf = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_addr] <= q_coeff;
        end
        rdata_reg <= mem[addr_reg];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start_eval)
        begin
            x_reg     <= q_x;
            y_reg     <= q_y;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            tx_reg[0] <= cheb2d_pkg::ONE_Q16;
            tx_reg[1] <= q_x;
            ty_reg[0] <= cheb2d_pkg::ONE_Q16;
            ty_reg[1] <= q_y;
            t1_reg    <= q_y;
            t2_reg    <= cheb2d_pkg::ONE_Q16;
        end
        else if (state_reg == S_TGEN)
        begin
            if (tgen_done)
            begin
                t1_reg <= x_reg;
                t2_reg <= cheb2d_pkg::ONE_Q16;
            end
            else
            begin
                if (axis_reg)
                begin
                    tx_reg[k_reg[MW-1:0]] <= tnew;
                end
                else
                begin
                    ty_reg[k_reg[NW-1:0]] <= tnew;
                end
                t2_reg <= t1_reg;
                t1_reg <= tnew;
            end
        end

        p1_reg <= rdata_reg * ty_reg[s1_n_reg];
        if (s2_v_reg)
        begin
            am_reg <= am_sum;
        end
        if (s2_v_reg && s2_lastn_reg)
        begin
            amr_reg <= am_rsum[SW:16];
        end
        p2_reg <= amr_reg * tx_reg[s3_m_reg];

        if (state_reg == S_TGEN && axis_reg && tgen_done)
        begin
            acc_reg <= '0;
        end
        else if (s4_v_reg)
        begin
            acc_reg <= acc_reg + ACW'(p2_reg);
        end

        if (state_reg == S_FIN && out_free)
        begin
            out_value_reg <= z_sat;
            out_ovf_reg   <= z_ovf;
        end
    end

    // sequencer, term counters, pipeline tags and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            k_reg         <= '0;
            m_reg         <= '0;
            n_reg         <= '0;
            addr_reg      <= '0;
            base_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_lastn_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_n_reg      <= '0;
            s1_m_reg      <= '0;
            s2_v_reg      <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_lastn_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            s2_m_reg      <= '0;
            s3_v_reg      <= 1'b0;
            s3_last_reg   <= 1'b0;
            s3_m_reg      <= '0;
            s4_v_reg      <= 1'b0;
            s4_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            s1_v_reg     <= (state_reg == S_ISSUE);
            s1_first_reg <= (n_reg == '0);
            s1_lastn_reg <= issue_lastn;
            s1_last_reg  <= issue_last;
            s1_n_reg     <= n_reg;
            s1_m_reg     <= m_reg;

            s2_v_reg     <= s1_v_reg;
            s2_first_reg <= s1_first_reg;
            s2_lastn_reg <= s1_lastn_reg;
            s2_last_reg  <= s1_last_reg;
            s2_m_reg     <= s1_m_reg;

            s3_v_reg     <= s2_v_reg && s2_lastn_reg;
            s3_last_reg  <= s2_last_reg;
            s3_m_reg     <= s2_m_reg;

            s4_v_reg     <= s3_v_reg;
            s4_last_reg  <= s3_last_reg;

            case (state_reg)
                S_IDLE:
                begin
                    if (start_eval)
                    begin
                        axis_reg  <= 1'b0;
                        k_reg     <= KW'(2);
                        state_reg <= S_TGEN;
                    end
                end
                S_TGEN:
                begin
                    if (tgen_done)
                    begin
                        if (axis_reg)
                        begin
                            m_reg     <= '0;
                            n_reg     <= '0;
                            addr_reg  <= '0;
                            base_reg  <= '0;
                            state_reg <= S_ISSUE;
                        end
                        else
                        begin
                            axis_reg <= 1'b1;
                            k_reg    <= KW'(2);
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_ISSUE:
                begin
                    if (issue_lastn)
                    begin
                        n_reg    <= '0;
                        m_reg    <= m_reg + 1'b1;
                        base_reg <= base_reg + ADW'(ROW);
                        addr_reg <= base_reg + ADW'(ROW);
                        if (issue_last)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                    else
                    begin
                        n_reg    <= n_reg + 1'b1;
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (s4_v_reg && s4_last_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_value = out_value_reg;
    assign rsp_ovf   = out_ovf_reg;

endmodule

`default_nettype wire

@@ hw/rtl/chebyshev_2d_series_eval.sv @@
// top level of the bivariate chebyshev series evaluator
// depends on cheb2d_pkg, cheb2d_if, cheb2d_front, cheb2d_back
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------------------
//   item     | in        | mode, order_x_index, order_y_index, coeff_value,
//            |           | x_point, y_point
//   result   | out       | series_value, overflow
//   cfg      | in        | cfg_we, cfg_index, cfg_wdata (degree_x, degree_y)
//
// a load request passes through the queue to the coefficient memory and gives no result
// an evaluate request works through (dx+1)*(dy+1) terms:
// one coefficient memory read and one multiply-accumulate per term, plus recurrence steps
// the front queue holds two requests and keeps accepting while the back end works or a
// result waits; a stalled result holds in the output register and stalls the back end
// reset clears control state only; the coefficient memory is undefined until loaded
`default_nettype none

module chebyshev_2d_series_eval #(
    parameter int MAX_ORDER_X = cheb2d_pkg::MAX_ORDER_X,
    parameter int MAX_ORDER_Y = cheb2d_pkg::MAX_ORDER_Y,
    parameter int COEFF_WIDTH = cheb2d_pkg::COEFF_WIDTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    cheb2d_item_if.sink                                 item,
    cheb2d_result_if.source                             result,
    input  logic                                        cfg_we,
    input  logic [cheb2d_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  logic [cheb2d_pkg::CFG_DATA_WIDTH-1:0]       cfg_wdata
);

    localparam int ADW = $clog2((MAX_ORDER_X + 1) * (MAX_ORDER_Y + 1));

    logic [cheb2d_pkg::DEG_WIDTH-1:0] degree_x_reg;
    logic [cheb2d_pkg::DEG_WIDTH-1:0] degree_y_reg;

    logic                                   q_valid;
    logic                                   q_ready;
    cheb2d_pkg::cmd_t                       q_cmd;
    logic [ADW-1:0]                         q_addr;
    logic signed [COEFF_WIDTH-1:0]          q_coeff;
    logic signed [cheb2d_pkg::PT_WIDTH-1:0] q_x;
    logic signed [cheb2d_pkg::PT_WIDTH-1:0] q_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_x_reg <= cheb2d_pkg::DEG_X_RESET;
            degree_y_reg <= cheb2d_pkg::DEG_Y_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cheb2d_pkg::CFG_DEGREE_X: degree_x_reg <= cfg_wdata;
                cheb2d_pkg::CFG_DEGREE_Y: degree_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    cheb2d_front #(
        .MAX_ORDER_X (MAX_ORDER_X),
        .MAX_ORDER_Y (MAX_ORDER_Y),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (item.valid),
        .in_ready      (item.ready),
        .mode          (item.mode),
        .order_x_index (item.order_x_index),
        .order_y_index (item.order_y_index),
        .coeff_value   (item.coeff_value),
        .x_point       (item.x_point),
        .y_point       (item.y_point),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .q_addr        (q_addr),
        .q_coeff       (q_coeff),
        .q_x           (q_x),
        .q_y           (q_y)
    );

    cheb2d_back #(
        .MAX_ORDER_X (MAX_ORDER_X),
        .MAX_ORDER_Y (MAX_ORDER_Y),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .q_addr    (q_addr),
        .q_coeff   (q_coeff),
        .q_x       (q_x),
        .q_y       (q_y),
        .degree_x  (degree_x_reg),
        .degree_y  (degree_y_reg),
        .rsp_valid (result.valid),
        .rsp_ready (result.ready),
        .rsp_value (result.series_value),
        .rsp_ovf   (result.overflow)
    );

endmodule

`default_nettype wire

@@ hw/rtl/cheb2d_checker.sv @@
// port-level checks on the result channel of the chebyshev series evaluator
// depends on cheb2d_pkg and assert_macros.svh; bound to chebyshev_2d_series_eval
`default_nettype none

`include "assert_macros.svh"

module cheb2d_port_checks (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  result_valid,
    input logic                                  result_ready,
    input logic [cheb2d_pkg::OUT_WIDTH-1:0]      series_value,
    input logic                                  overflow
);

    localparam int OW = cheb2d_pkg::OUT_WIDTH;
    localparam logic [OW-1:0] SAT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] SAT_MIN = {1'b1, {(OW-1){1'b0}}};

    `CHEB_ASSERT(a_valid_hold,
        result_valid && !result_ready |=> result_valid,
        "result dropped while stalled")
    `CHEB_ASSERT(a_value_hold,
        result_valid && !result_ready |=> $stable(series_value),
        "result changed while stalled")
    `CHEB_ASSERT(a_ovf_sat,
        result_valid && overflow |-> series_value == SAT_MAX || series_value == SAT_MIN,
        "overflow without saturated value")
    `CHEB_ASSERT_ALWAYS(a_reset_quiet,
        !rst_n |-> !result_valid,
        "result valid during reset")

endmodule

bind chebyshev_2d_series_eval cheb2d_port_checks u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .series_value (result.series_value),
    .overflow     (result.overflow)
);

`default_nettype wire
